### rtl/fsf_pkg.sv
// fsf_pkg: shared constants, command codes and the job record for the shape fill engine
// no dependencies; imported by every other file of the block

package fsf_pkg;

	// frame store geometry
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// field widths
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 2;
	localparam int POS_W     = 9;
	localparam int DIM_W     = 8;
	localparam int COLOR_W   = 32;
	localparam int RR_W      = 2 * DIM_W;
	localparam int EXT_W     = 11;
	localparam int DIFF_W    = 10;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int PROD_W    = 2 * CFG_W;

	// job queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST  = 7'd64;
	localparam logic [CFG_W-1:0] ACTIVE_HEIGHT_RST = 7'd64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_FILL_ALL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECT     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DISC     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

	// what the back end does with a job
	typedef enum logic [1:0] {
		JOB_SKIP = 2'd0,
		JOB_FILL = 2'd1,
		JOB_DISC = 2'd2,
		JOB_READ = 2'd3
	} job_op_t;

	// classified command, clipped to the active area
	typedef struct packed {
		job_op_t                  op;
		logic [CFG_W-1:0]         x0;
		logic [CFG_W-1:0]         x1;
		logic [CFG_W-1:0]         y0;
		logic [CFG_W-1:0]         y1;
		logic [CFG_W-1:0]         stride;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic [RR_W-1:0]          rr;
		logic [COLOR_W-1:0]       color;
		logic [ADDR_W-1:0]        addr;
	} job_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
		logic walking;
	} back_stat_t;

endpackage

### rtl/fsf_ifs.sv
// fsf_req_if and fsf_rsp_if: valid/ready channels for commands and results
// depends on fsf_pkg for the field widths

interface fsf_req_if;
	import fsf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [POS_W-1:0]  x_pos;
	logic signed [POS_W-1:0]  y_pos;
	logic [DIM_W-1:0]         box_width;
	logic [DIM_W-1:0]         box_height;
	logic [DIM_W-1:0]         radius;
	logic [COLOR_W-1:0]       color;

	modport source (output valid, cmd, x_pos, y_pos, box_width, box_height, radius, color,
		input ready);
	modport sink (input valid, cmd, x_pos, y_pos, box_width, box_height, radius, color,
		output ready);
endinterface

interface fsf_rsp_if;
	import fsf_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_value;
	logic               in_area;

	modport source (output valid, pixel_value, in_area, input ready);
	modport sink (input valid, pixel_value, in_area, output ready);
endinterface

### rtl/fsf_front.sv
// fsf_front: holds the area registers, accepts commands and clips them into jobs
// depends on fsf_pkg and fsf_req_if

module fsf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	fsf_req_if.sink                       req,
	input  logic                          cfg_we,
	input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsf_pkg::CFG_W-1:0]     cfg_wdata,
	input  fsf_pkg::back_stat_t           stat,
	input  logic                          q_full,
	output logic                          q_push,
	output fsf_pkg::job_t                 q_job
);
	import fsf_pkg::*;

	logic [CFG_W-1:0]        active_width_q;
	logic [CFG_W-1:0]        active_height_q;
	logic [CFG_W-1:0]        w_eff;
	logic [CFG_W-1:0]        h_eff;
	logic signed [EXT_W-1:0] w_e, h_e, px_e, py_e, bw_e, bh_e, r_e;
	logic signed [EXT_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [EXT_W-1:0] cx0, cx1, cy0, cy1;
	logic                    nonempty;
	logic [CFG_W-1:0]        col;
	logic [PROD_W-1:0]       row_base;
	logic [PROD_W-1:0]       addr_sum;

	// area registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= ACTIVE_WIDTH_RST;
			active_height_q <= ACTIVE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  active_width_q  <= cfg_wdata;
				REG_ACTIVE_HEIGHT: active_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective area, limited to the store size
	always_comb begin
		if (32'(active_width_q) > MAX_WIDTH) w_eff = CFG_W'(MAX_WIDTH);
		else w_eff = active_width_q;
		if (32'(active_height_q) > MAX_HEIGHT) h_eff = CFG_W'(MAX_HEIGHT);
		else h_eff = active_height_q;
	end

	// handshake: no transfer during the clearing pass or with the queue full
	assign req.ready = !stat.clearing && !q_full;
	assign q_push    = req.valid && req.ready;

	// unclipped box of the command; a read is a one-pixel box
	always_comb begin
		w_e  = signed'(EXT_W'(w_eff));
		h_e  = signed'(EXT_W'(h_eff));
		px_e = EXT_W'(req.x_pos);
		py_e = EXT_W'(req.y_pos);
		bw_e = signed'(EXT_W'(req.box_width));
		bh_e = signed'(EXT_W'(req.box_height));
		r_e  = signed'(EXT_W'(req.radius));
		case (req.cmd)
			CMD_FILL_ALL: begin
				lo_x = '0;
				hi_x = w_e;
				lo_y = '0;
				hi_y = h_e;
			end
			CMD_RECT: begin
				lo_x = px_e;
				hi_x = px_e + bw_e;
				lo_y = py_e;
				hi_y = py_e + bh_e;
			end
			CMD_DISC: begin
				lo_x = px_e - r_e;
				hi_x = px_e + r_e;
				lo_y = py_e - r_e;
				hi_y = py_e + r_e;
			end
			CMD_READ: begin
				lo_x = px_e;
				hi_x = px_e + EXT_W'(1);
				lo_y = py_e;
				hi_y = py_e + EXT_W'(1);
			end
			default: begin
				lo_x = '0;
				hi_x = '0;
				lo_y = '0;
				hi_y = '0;
			end
		endcase
	end

	// clip to the active area
	always_comb begin
		cx0 = (lo_x < 0) ? '0 : lo_x;
		cy0 = (lo_y < 0) ? '0 : lo_y;
		cx1 = (hi_x > w_e) ? w_e : hi_x;
		cy1 = (hi_y > h_e) ? h_e : hi_y;
		nonempty = (cx0 < cx1) && (cy0 < cy1);
	end

	// start address: first row base for draws, pixel address for reads
	always_comb begin
		col      = (req.cmd == CMD_READ) ? cx0[CFG_W-1:0] : '0;
		row_base = PROD_W'(cy0[CFG_W-1:0]) * PROD_W'(w_eff);
		addr_sum = row_base + PROD_W'(col);
	end

	// job record
	always_comb begin
		q_job.x0     = cx0[CFG_W-1:0];
		q_job.x1     = cx1[CFG_W-1:0];
		q_job.y0     = cy0[CFG_W-1:0];
		q_job.y1     = cy1[CFG_W-1:0];
		q_job.stride = w_eff;
		q_job.px     = req.x_pos;
		q_job.py     = req.y_pos;
		q_job.rr     = RR_W'(req.radius) * RR_W'(req.radius);
		q_job.color  = req.color;
		q_job.addr   = ADDR_W'(addr_sum);
		if (!nonempty) begin
			q_job.op = JOB_SKIP;
		end else begin
			case (req.cmd)
				CMD_FILL_ALL: q_job.op = JOB_FILL;
				CMD_RECT:     q_job.op = JOB_FILL;
				CMD_DISC:     q_job.op = JOB_DISC;
				CMD_READ:     q_job.op = JOB_READ;
				default:      q_job.op = JOB_SKIP;
			endcase
		end
	end

endmodule

### rtl/fsf_queue.sv
// fsf_queue: short job queue between the front and back ends
// depends on fsf_pkg for the job record and depth

module fsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fsf_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output fsf_pkg::job_t head
);
	import fsf_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == QPTR_W'(QDEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				if (rd_ptr_q == QPTR_W'(QDEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

### rtl/fsf_back.sv
// fsf_back: frame store, clearing pass, pixel walker with disc test, result register
// depends on fsf_pkg and fsf_rsp_if

module fsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  fsf_pkg::job_t       q_head,
	output logic                q_pop,
	output fsf_pkg::back_stat_t stat,
	fsf_rsp_if.source           rsp
);
	import fsf_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_ROUT  = 5'b10000
	} back_state_t;

	back_state_t              state_q, state_d;
	logic [ADDR_W-1:0]        clr_q;
	job_t                     job_q;
	logic [CFG_W-1:0]         x_q, y_q, x_nxt, y_nxt;
	logic [ADDR_W-1:0]        base_q;
	logic                     last_col, last_row;
	logic signed [DIFF_W-1:0] dx, dy;

	logic                     valid_s1, valid_s2;
	logic [ADDR_W-1:0]        addr_s1, addr_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0]          dx2_s2, dy2_s2;
	logic                     covered_s2;

	logic [COLOR_W-1:0]       mem [DEPTH];
	logic                     mem_we, mem_re;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [COLOR_W-1:0]       mem_wdata;
	logic [COLOR_W-1:0]       rdata_q;

	logic                     slot_free, load_res, res_in;
	logic [COLOR_W-1:0]       res_pix;
	logic                     rsp_valid_q, rsp_in_q;
	logic [COLOR_W-1:0]       rsp_pix_q;

	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.walking  = (state_q == ST_WALK);
	assign slot_free     = !rsp_valid_q || rsp.ready;

	// walker position
	always_comb begin
		x_nxt    = x_q + CFG_W'(1);
		y_nxt    = y_q + CFG_W'(1);
		last_col = (x_nxt == job_q.x1);
		last_row = (y_nxt == job_q.y1);
		dx       = signed'(DIFF_W'(x_q)) - DIFF_W'(job_q.px);
		dy       = signed'(DIFF_W'(y_q)) - DIFF_W'(job_q.py);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_res = 1'b0;
		res_pix  = '0;
		res_in   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					if (q_head.op == JOB_READ) begin
						q_pop   = 1'b1;
						state_d = ST_ROUT;
					end else if (slot_free) begin
						// draws answer with an empty result right away
						q_pop    = 1'b1;
						load_res = 1'b1;
						if (q_head.op == JOB_FILL || q_head.op == JOB_DISC) state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (last_col && last_row) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) state_d = ST_IDLE;
			end
			ST_ROUT: begin
				if (slot_free) begin
					load_res = 1'b1;
					res_pix  = rdata_q;
					res_in   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_WALK);
			valid_s2 <= valid_s1;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (load_res) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// job capture and raster walk, row base advances by the stride
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= q_head;
			x_q    <= q_head.x0;
			y_q    <= q_head.y0;
			base_q <= q_head.addr;
		end else if (state_q == ST_WALK) begin
			if (last_col) begin
				x_q    <= job_q.x0;
				y_q    <= y_nxt;
				base_q <= base_q + ADDR_W'(job_q.stride);
			end else begin
				x_q <= x_nxt;
			end
		end
	end

	// pixel pipeline: offsets, then squares
	always_ff @(posedge clk) begin
		addr_s1 <= base_q + ADDR_W'(x_q);
		dx_s1   <= dx;
		dy_s1   <= dy;
		addr_s2 <= addr_s1;
		dx2_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		dy2_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
	end

	// disc test against radius squared
	assign covered_s2 = ((SQ_W + 1)'(dx2_s2) + (SQ_W + 1)'(dy2_s2)) <= (SQ_W + 1)'(job_q.rr);

	// write port: clearing pass or covered pixel
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s2;
		mem_wdata = job_q.color;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (valid_s2 && (job_q.op == JOB_FILL || covered_s2)) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = q_pop && (q_head.op == JOB_READ);

	// frame store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[q_head.addr];
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_res) begin
			rsp_pix_q <= res_pix;
			rsp_in_q  <= res_in;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.pixel_value = rsp_pix_q;
	assign rsp.in_area     = rsp_in_q;

endmodule

### rtl/framebuffer_shape_fill_core.sv
// framebuffer_shape_fill_core: 2D fill engine over a 64 x 64 store of 32-bit colour words
// depends on fsf_pkg, fsf_ifs, fsf_front, fsf_queue and fsf_back
//
// Commands enter on req (valid/ready); each gives exactly one result on rsp.
// Fill all, fill rectangle and fill disc are clipped to the active area set
// by the active_width / active_height registers (cfg_we, cfg_index,
// cfg_wdata); the user must write them only while the engine is idle, which
// the block does not enforce. Read pixel returns the stored word with in_area
// set, or zero with in_area clear outside the area. A front end clips each
// command into a job and pushes it into a two-entry queue; the back end walks
// the clipped box one pixel per cycle through a two-stage offset/square
// pipeline into the single write port of the store. A draw result (all zero)
// is posted when its job starts; a draw occupies the back end while it walks
// its clipped box and drains the pipeline. A read result is loaded once the
// result register is free; reads wait behind earlier draws.
// After reset a clearing pass writes zero to all 4096 words, one per cycle;
// req.ready stays low during it, register writes are taken as usual.
// When rsp stalls the result register holds, the queue fills and req.ready
// drops.

module framebuffer_shape_fill_core (
	input  logic                          clk,
	input  logic                          arst_n,
	fsf_req_if.sink                       req,
	fsf_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsf_pkg::CFG_W-1:0]     cfg_wdata
);
	import fsf_pkg::*;

	back_stat_t stat;
	logic       q_push, q_full, q_valid, q_pop;
	job_t       push_job, q_head;

	// command intake and clipping
	fsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	// job queue
	fsf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	// store, walker and results
	fsf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.stat    (stat),
		.rsp     (rsp)
	);

`ifndef NO_ASSERTIONS
	// results outside the area carry no colour
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.in_area |-> rsp.pixel_value == '0)
		else $error("result without in_area carries a colour");

	// nothing reaches the queue during the clearing pass
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !q_valid)
		else $error("job queued during clearing pass");

	// the clearing pass runs only once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.clearing |=> !stat.clearing)
		else $error("clearing pass restarted");

	// no job is taken while a box is being walked, and only from a filled queue
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && !stat.walking)
		else $error("job popped while walking or from empty queue");
`endif

endmodule
